FILE: hw/rtl/rtra_pkg.sv
`default_nettype none

package rtra_pkg;

    // Defaults for the top-level parameters
    localparam int unsigned STORE_BYTES_DEF = 65536;
    localparam int unsigned BLOCK_BYTES_DEF = 256;
    localparam int unsigned POS_BITS_DEF    = 32;

    // Run-length ROM: RUN_CODES powers of 1.2, then one zero entry
    localparam int unsigned RUN_CODES = 85;
    localparam int unsigned LEN_W     = 23;   // round(1.2^84) < 2^23

    // Operation codes (tuser)
    localparam logic [1:0] FUNC_CLEAR  = 2'd0;
    localparam logic [1:0] FUNC_APPEND = 2'd1;
    localparam logic [1:0] FUNC_QUERY  = 2'd2;

    // Result status codes
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_RANGE    = 2'd1;
    localparam logic [1:0] STAT_MISMATCH = 2'd2;
    localparam logic [1:0] STAT_FULL     = 2'd3;

    typedef struct packed {
        logic [LEN_W-1:0] len;
        logic [1:0]       val;
    } code_info_t;

    typedef code_info_t [255:0] code_rom_t;

    // Controller -> datapath
    typedef struct packed {
        logic capture;
        logic exec;
        logic srch_issue;
        logic srch_cmp;
        logic walk_init;
        logic walk;
        logic emit;
    } cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic need_search;
        logic srch_more;
        logic walk_done;
        logic out_free;
    } sts_t;

    // Elaboration-time ROM build: powers of 6/5 in 64.64 fixed point,
    // rounded half up, indexed directly by the code byte.
    function automatic code_rom_t build_code_rom();
        longint unsigned  ip;
        longint unsigned  fr;
        longint unsigned  p0;
        longint unsigned  p1;
        longint unsigned  low;
        longint unsigned  carry;
        longint unsigned  n;
        longint unsigned  rem;
        longint unsigned  t;
        longint unsigned  q1;
        longint unsigned  q0;
        logic [LEN_W-1:0] runlen [0:RUN_CODES];
        code_rom_t        rom;
        ip = 64'd1;
        fr = 64'd0;
        for (int k = 0; k < RUN_CODES; k++)
        begin
            runlen[k] = LEN_W'(ip + (fr >> 63));
            p0    = (fr & 64'hFFFF_FFFF) * 64'd6;
            p1    = (fr >> 32) * 64'd6 + (p0 >> 32);
            low   = (p1 << 32) | (p0 & 64'hFFFF_FFFF);
            carry = p1 >> 32;
            n     = ip * 64'd6 + carry;
            ip    = n / 64'd5;
            rem   = n % 64'd5;
            t     = (rem << 32) | (low >> 32);
            q1    = t / 64'd5;
            t     = ((t % 64'd5) << 32) | (low & 64'hFFFF_FFFF);
            q0    = t / 64'd5;
            fr    = (q1 << 32) | q0;
        end
        runlen[RUN_CODES] = '0;
        for (int b = 0; b < 256; b++)
        begin
            rom[b].len = runlen[b / 3];
            rom[b].val = 2'(b % 3);
        end
        return rom;
    endfunction

    localparam code_rom_t CODE_ROM = build_code_rom();

endpackage

`default_nettype wire

FILE: hw/rtl/rle_table_random_access_core.sv
// Random-access reader for a run-length coded table.
// Slave stream: tuser = operation (clear / append code byte / query
// position), tdata = code byte and query position. Master stream: one
// result transfer per input transfer, tdata = value and status.
// cfg channel writes the expected uncompressed table length; write it only
// while the block is idle. cfg_ready is always high.
// Flow per item: clear, append, unused op and error query finish in the
// execute state. A valid query then runs a binary search over the loaded
// block starts (at most ceil(log2(blocks)) steps, 8 at defaults), each step
// an issue and a compare on the block-start memory, and then walks the code
// bytes from the start of the found block until the position falls in a run
// or the loaded bytes run out. One code byte per cycle from the store's
// single read port.
// One item is in work at a time; tready comes back in the first cycle the
// result sits in the output register. A stalled receiver holds the result
// and, once a second result is ready, holds the input side off.
// Reset empties the table (no bytes, running total 0) and sets the
// expected length to 0. Memories are not cleared; only written entries
// are ever read.

`default_nettype none

module rle_table_random_access_core #(
    parameter int unsigned STORE_BYTES = rtra_pkg::STORE_BYTES_DEF,
    parameter int unsigned BLOCK_BYTES = rtra_pkg::BLOCK_BYTES_DEF,
    parameter int unsigned POS_BITS    = rtra_pkg::POS_BITS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Input stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,   // [7:0] code_byte, [39:8] query_pos
    input  wire logic [1:0]  s_axis_tuser,   // [1:0] func
    // Result stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // [1:0] value, [3:2] status, [7:4] zero
    // Configuration: total_size
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [31:0] cfg_data
);

    rtra_pkg::cmd_t cmd;
    rtra_pkg::sts_t sts;
    logic [1:0]     res_value;
    logic [1:0]     res_status;

    // Sequencer: accept, execute, block search, block walk, hand-off
    rtra_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Table state, code store, block-start memory and output register
    rtra_dpath #(
        .STORE_BYTES (STORE_BYTES),
        .BLOCK_BYTES (BLOCK_BYTES),
        .POS_BITS    (POS_BITS)
    ) u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_func    (s_axis_tuser),
        .in_code    (s_axis_tdata[7:0]),
        .in_pos     (s_axis_tdata[39:8]),
        .cfg_we     (cfg_valid),
        .cfg_data   (cfg_data),
        .cmd        (cmd),
        .sts        (sts),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_value  (res_value),
        .out_status (res_status)
    );

    assign cfg_ready    = 1'b1;
    assign m_axis_tdata = {4'b0000, res_status, res_value};

endmodule

`default_nettype wire

FILE: hw/rtl/rtra_ctrl.sv
`default_nettype none

module rtra_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire rtra_pkg::sts_t sts,
    output rtra_pkg::cmd_t     cmd
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_EXEC   = 7'b0000010,
        S_SISSUE = 7'b0000100,
        S_SCMP   = 7'b0001000,
        S_BASE   = 7'b0010000,
        S_WALK   = 7'b0100000,
        S_DONE   = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
                if (in_valid)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = sts.need_search ? S_SISSUE : S_DONE;
            end
            S_SISSUE:
            begin
                cmd.srch_issue = 1'b1;
                state_next     = sts.srch_more ? S_SCMP : S_BASE;
            end
            S_SCMP:
            begin
                cmd.srch_cmp = 1'b1;
                state_next   = S_SISSUE;
            end
            S_BASE:
            begin
                cmd.walk_init = 1'b1;
                state_next    = S_WALK;
            end
            S_WALK:
            begin
                cmd.walk = 1'b1;
                if (sts.walk_done)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                cmd.emit = sts.out_free;
                if (sts.out_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

FILE: hw/rtl/rtra_dpath.sv
`default_nettype none

module rtra_dpath #(
    parameter int unsigned STORE_BYTES = rtra_pkg::STORE_BYTES_DEF,
    parameter int unsigned BLOCK_BYTES = rtra_pkg::BLOCK_BYTES_DEF,
    parameter int unsigned POS_BITS    = rtra_pkg::POS_BITS_DEF
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic [1:0]     in_func,
    input  wire logic [7:0]     in_code,
    input  wire logic [31:0]    in_pos,
    input  wire logic           cfg_we,
    input  wire logic [31:0]    cfg_data,
    input  wire rtra_pkg::cmd_t cmd,
    output rtra_pkg::sts_t      sts,
    output logic                out_valid,
    input  wire logic           out_ready,
    output logic [1:0]          out_value,
    output logic [1:0]          out_status
);

    localparam int unsigned NUM_BLOCKS = (STORE_BYTES + BLOCK_BYTES - 1) / BLOCK_BYTES;
    localparam int unsigned CNT_W      = $clog2(STORE_BYTES + 1);
    localparam int unsigned ADDR_W     = $clog2(STORE_BYTES);
    localparam int unsigned OFF_W      = $clog2(BLOCK_BYTES);
    localparam int unsigned NBLK_W     = $clog2(NUM_BLOCKS + 1);
    localparam int unsigned BLK_W      = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;

    // Storage
    logic [7:0]          code_mem [0:STORE_BYTES-1];
    logic [POS_BITS-1:0] bs_mem   [0:NUM_BLOCKS-1];
    logic [7:0]          code_q_reg;
    logic [POS_BITS-1:0] bs_q_reg;

    // Item
    logic [1:0]          func_reg;
    logic [7:0]          code_reg;
    logic [POS_BITS-1:0] pos_reg;
    logic [31:0]         total_size_reg;

    // Table state
    logic [CNT_W-1:0]    bytes_loaded_reg, bytes_loaded_next;
    logic [OFF_W-1:0]    blk_off_reg, blk_off_next;
    logic [NBLK_W-1:0]   nblk_reg, nblk_next;
    logic [POS_BITS-1:0] running_total_reg, running_total_next;

    // Query state
    logic [BLK_W-1:0]    lo_reg, lo_next;
    logic [BLK_W-1:0]    hi_reg, hi_next;
    logic [BLK_W-1:0]    mid_reg, mid_next;
    logic [POS_BITS-1:0] rest_reg, rest_next;
    logic [CNT_W-1:0]    issue_idx_reg, issue_idx_next;
    logic                data_vld_reg, data_vld_next;

    // Result and output register
    logic [1:0]          res_value_reg, res_value_next;
    logic [1:0]          res_status_reg, res_status_next;
    logic                out_valid_reg, out_valid_next;
    logic [1:0]          out_value_reg, out_value_next;
    logic [1:0]          out_status_reg, out_status_next;

    logic [POS_BITS-1:0]   size;
    logic                  full;
    logic                  sizes_match;
    logic                  pos_ok;
    logic                  code_we;
    logic                  bs_we;
    rtra_pkg::code_info_t  app_info;
    rtra_pkg::code_info_t  walk_info;
    logic [POS_BITS-1:0]   walk_len;
    logic                  hit;
    logic                  more;
    logic [BLK_W:0]        mid_sum;
    logic [BLK_W-1:0]      mid;
    logic [BLK_W-1:0]      bs_rd_idx;

    assign size        = POS_BITS'(total_size_reg);
    assign full        = (bytes_loaded_reg == CNT_W'(STORE_BYTES));
    assign sizes_match = (running_total_reg == size);
    assign pos_ok      = (pos_reg < size) && (bytes_loaded_reg != '0);
    assign app_info    = rtra_pkg::CODE_ROM[code_reg];
    assign walk_info   = rtra_pkg::CODE_ROM[code_q_reg];
    assign walk_len    = POS_BITS'(walk_info.len);
    assign hit         = data_vld_reg && (rest_reg < walk_len);
    assign more        = (issue_idx_reg < bytes_loaded_reg);

    // Upper midpoint of [lo, hi]
    assign mid_sum   = {1'b0, lo_reg} + {1'b0, hi_reg} + (BLK_W + 1)'(1);
    assign mid       = mid_sum[BLK_W:1];
    assign bs_rd_idx = (lo_reg < hi_reg) ? mid : lo_reg;

    assign code_we = cmd.exec && (func_reg == rtra_pkg::FUNC_APPEND) && !full;
    assign bs_we   = code_we && (blk_off_reg == '0);

    always_comb
    begin
        sts.need_search = (func_reg == rtra_pkg::FUNC_QUERY) && sizes_match && pos_ok;
        sts.srch_more   = (lo_reg < hi_reg);
        sts.walk_done   = hit || (!data_vld_reg && !more);
        sts.out_free    = !out_valid_reg || out_ready;
    end

    always_comb
    begin
        bytes_loaded_next  = bytes_loaded_reg;
        blk_off_next       = blk_off_reg;
        nblk_next          = nblk_reg;
        running_total_next = running_total_reg;
        lo_next            = lo_reg;
        hi_next            = hi_reg;
        mid_next           = mid_reg;
        rest_next          = rest_reg;
        issue_idx_next     = issue_idx_reg;
        data_vld_next      = data_vld_reg;
        res_value_next     = res_value_reg;
        res_status_next    = res_status_reg;

        if (cmd.exec)
        begin
            res_value_next  = 2'd0;
            res_status_next = rtra_pkg::STAT_OK;
            case (func_reg)
                rtra_pkg::FUNC_CLEAR:
                begin
                    bytes_loaded_next  = '0;
                    blk_off_next       = '0;
                    nblk_next          = '0;
                    running_total_next = '0;
                end
                rtra_pkg::FUNC_APPEND:
                begin
                    if (full)
                    begin
                        res_status_next = rtra_pkg::STAT_FULL;
                    end
                    else
                    begin
                        bytes_loaded_next  = bytes_loaded_reg + CNT_W'(1);
                        running_total_next = running_total_reg + POS_BITS'(app_info.len);
                        if (blk_off_reg == '0)
                            nblk_next = nblk_reg + NBLK_W'(1);
                        if (blk_off_reg == OFF_W'(BLOCK_BYTES - 1))
                            blk_off_next = '0;
                        else
                            blk_off_next = blk_off_reg + OFF_W'(1);
                    end
                end
                rtra_pkg::FUNC_QUERY:
                begin
                    if (!sizes_match)
                    begin
                        res_status_next = rtra_pkg::STAT_MISMATCH;
                    end
                    else if (!pos_ok)
                    begin
                        res_status_next = rtra_pkg::STAT_RANGE;
                    end
                    else
                    begin
                        lo_next = '0;
                        hi_next = BLK_W'(nblk_reg - NBLK_W'(1));
                    end
                end
                default:
                begin
                    res_status_next = rtra_pkg::STAT_OK;
                end
            endcase
        end

        if (cmd.srch_issue)
            mid_next = mid;

        if (cmd.srch_cmp)
        begin
            if (bs_q_reg <= pos_reg)
                lo_next = mid_reg;
            else
                hi_next = mid_reg - BLK_W'(1);
        end

        if (cmd.walk_init)
        begin
            rest_next      = pos_reg - bs_q_reg;
            issue_idx_next = CNT_W'(lo_reg) * CNT_W'(BLOCK_BYTES);
            data_vld_next  = 1'b0;
        end

        if (cmd.walk)
        begin
            // one read in flight: issue the next byte while checking the last
            if (more)
            begin
                issue_idx_next = issue_idx_reg + CNT_W'(1);
                data_vld_next  = 1'b1;
            end
            else
            begin
                data_vld_next = 1'b0;
            end
            if (data_vld_reg && !hit)
                rest_next = rest_reg - walk_len;
            if (hit)
            begin
                res_value_next  = walk_info.val;
                res_status_next = rtra_pkg::STAT_OK;
            end
            else if (!data_vld_reg && !more)
            begin
                res_value_next  = 2'd0;
                res_status_next = rtra_pkg::STAT_RANGE;
            end
        end
    end

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;
        if (cmd.emit)
        begin
            out_valid_next  = 1'b1;
            out_value_next  = res_value_reg;
            out_status_next = res_status_reg;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Memories: one write port, one registered read port each
    always_ff @(posedge clk)
    begin
        if (code_we)
            code_mem[bytes_loaded_reg[ADDR_W-1:0]] <= code_reg;
        code_q_reg <= code_mem[issue_idx_reg[ADDR_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (bs_we)
            bs_mem[nblk_reg[BLK_W-1:0]] <= running_total_reg;
        bs_q_reg <= bs_mem[bs_rd_idx];
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            func_reg <= in_func;
            code_reg <= in_code;
            pos_reg  <= POS_BITS'(in_pos);
        end
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        mid_reg        <= mid_next;
        rest_reg       <= rest_next;
        issue_idx_reg  <= issue_idx_next;
        res_value_reg  <= res_value_next;
        res_status_reg <= res_status_next;
        out_value_reg  <= out_value_next;
        out_status_reg <= out_status_next;
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_size_reg    <= '0;
            bytes_loaded_reg  <= '0;
            blk_off_reg       <= '0;
            nblk_reg          <= '0;
            running_total_reg <= '0;
            data_vld_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                total_size_reg <= cfg_data;
            bytes_loaded_reg  <= bytes_loaded_next;
            blk_off_reg       <= blk_off_next;
            nblk_reg          <= nblk_next;
            running_total_reg <= running_total_next;
            data_vld_reg      <= data_vld_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_value  = out_value_reg;
    assign out_status = out_status_reg;

endmodule

`default_nettype wire

FILE: dv/rle_table_random_access_core_test.sv
`default_nettype none

module rle_table_random_access_core_test;

    localparam int unsigned STORE_N     = rtra_pkg::STORE_BYTES_DEF;
    localparam int unsigned BLOCK_N     = rtra_pkg::BLOCK_BYTES_DEF;
    localparam int unsigned BLOCK_COUNT = (STORE_N + BLOCK_N - 1) / BLOCK_N;

    // func code 3 has no meaning; the block answers it with a plain ok
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    // Receiver hold-off length, in cycles, for the back-pressure test
    localparam int unsigned HOLD_CYCLES = 400;

    typedef struct packed {
        logic [1:0] status;
        logic [1:0] value;
    } lookup_result_t;

    // Shadow copy of the run-length table plus the queue of lookup results
    // still owed by the block.
    class rle_lookup_board;
        int unsigned    run_len_of [256];
        logic [7:0]     codes [];
        logic [31:0]    block_base [];
        int unsigned    bytes_held;
        logic [31:0]    run_sum;
        logic [31:0]    table_len;
        lookup_result_t owed [$];
        int unsigned    errors;

        function new();
            real         pw;
            int unsigned len_k [0:rtra_pkg::RUN_CODES];
            pw = 1.0;
            for (int k = 0; k < rtra_pkg::RUN_CODES; k++)
            begin
                len_k[k] = $rtoi(pw + 0.5);
                pw = pw * 1.2;
            end
            // last code group is the zero-length run
            len_k[rtra_pkg::RUN_CODES] = 0;
            for (int b = 0; b < 256; b++)
                run_len_of[b] = len_k[b / 3];
            codes      = new[STORE_N];
            block_base = new[BLOCK_COUNT];
            bytes_held = 0;
            run_sum    = '0;
            table_len  = '0;
            errors     = 0;
        endfunction

        function void note_input(logic [1:0] op, logic [7:0] cb, logic [31:0] pos);
            lookup_result_t r;
            int unsigned    lo;
            int unsigned    hi;
            int unsigned    mid;
            int unsigned    nblk;
            logic [31:0]    rest;
            bit             found;
            r = '0;
            case (op)
                rtra_pkg::FUNC_CLEAR:
                begin
                    bytes_held = 0;
                    run_sum    = '0;
                end
                rtra_pkg::FUNC_APPEND:
                begin
                    if (bytes_held >= STORE_N)
                        r.status = rtra_pkg::STAT_FULL;
                    else
                    begin
                        if (bytes_held % BLOCK_N == 0)
                            block_base[bytes_held / BLOCK_N] = run_sum;
                        codes[bytes_held] = cb;
                        bytes_held++;
                        run_sum = run_sum + run_len_of[cb];
                    end
                end
                rtra_pkg::FUNC_QUERY:
                begin
                    if (run_sum != table_len)
                        r.status = rtra_pkg::STAT_MISMATCH;
                    else if (pos >= table_len || bytes_held == 0)
                        r.status = rtra_pkg::STAT_RANGE;
                    else
                    begin
                        // last block whose start is not past pos
                        nblk = (bytes_held + BLOCK_N - 1) / BLOCK_N;
                        lo   = 0;
                        hi   = nblk - 1;
                        while (lo < hi)
                        begin
                            mid = (lo + hi + 1) / 2;
                            if (block_base[mid] <= pos)
                                lo = mid;
                            else
                                hi = mid - 1;
                        end
                        rest  = pos - block_base[lo];
                        found = 1'b0;
                        for (int unsigned i = lo * BLOCK_N; i < bytes_held; i++)
                        begin
                            if (rest < run_len_of[codes[i]])
                            begin
                                r.value = 2'(codes[i] % 8'd3);
                                found   = 1'b1;
                                break;
                            end
                            rest = rest - run_len_of[codes[i]];
                        end
                        if (!found)
                            r.status = rtra_pkg::STAT_RANGE;
                    end
                end
                default: ;
            endcase
            owed.insert(owed.size(), r);
        endfunction

        function void check_result(logic [7:0] td);
            lookup_result_t got;
            lookup_result_t want;
            got.value  = td[1:0];
            got.status = td[3:2];
            if (owed.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("result with nothing owed: value %0d status %0d",
                             got.value, got.status);
                return;
            end
            want = owed.pop_front();
            if (got.value !== want.value || got.status !== want.status)
            begin
                errors++;
                if (errors <= 10)
                    $display({"lookup mismatch: expected value %0d status %0d, ",
                              "got value %0d status %0d"},
                             want.value, want.status, got.value, got.status);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;   // [7:0] code_byte, [39:8] query_pos
    logic [1:0]  s_axis_tuser;   // [1:0] func
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;   // [1:0] value, [3:2] status, [7:4] zero
    logic        cfg_valid;
    logic        cfg_ready;
    logic [31:0] cfg_data;

    rle_lookup_board board;
    bit              calm;          // no idling on either side while set
    bit              hold_request;  // asks the receiver for one long hold-off
    int unsigned     items_sent;

    rle_table_random_access_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Generous run limit for the whole test.
    initial
    begin
        #20000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // One input transfer. Random gaps before it unless calm is set; tvalid
    // stays high into the next call when there is no gap.
    task automatic send_item(input logic [1:0] op, input logic [7:0] cb,
                             input logic [31:0] pos);
        while (!calm && $urandom_range(99) < 8)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {pos, cb};
        do
            @(posedge clk);
        while (!s_axis_tready);
        board.note_input(op, cb, pos);
        if (op != FUNC_UNUSED)
            items_sent++;
    endtask

    // Length register write, only once the block has drained.
    task automatic write_table_len(input logic [31:0] v);
        s_axis_tvalid <= 1'b0;
        while (board.owed.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        board.table_len = v;
    endtask

    // mode 0: any byte, 1: short runs, 2: long runs, 3: many zero-length runs
    function automatic logic [7:0] pick_code(input int unsigned mode);
        case (mode)
            1:       return 8'($urandom_range(59, 0));
            2:       return 8'($urandom_range(255, 228));
            3:       return ($urandom_range(3) == 0) ? 8'hFF : 8'($urandom());
            default: return 8'($urandom());
        endcase
    endfunction

    // Mostly positions inside the table, with its edges and wild values mixed in
    function automatic logic [31:0] pick_pos();
        int unsigned sel;
        sel = $urandom_range(99);
        if (board.table_len == 0 || sel >= 90)
            return $urandom();
        if (sel < 70)
            return $urandom_range(board.table_len - 1, 0);
        if (sel < 78)
            return 32'h0;
        if (sel < 85)
            return board.table_len - 1;
        return board.table_len;
    endfunction

    task automatic load_table(input int unsigned n, input int unsigned mode);
        for (int unsigned i = 0; i < n; i++)
        begin
            if ($urandom_range(99) < 3)
                send_item(FUNC_UNUSED, 8'($urandom()), $urandom());
            send_item(rtra_pkg::FUNC_APPEND, pick_code(mode), $urandom());
        end
    endtask

    // Queries with an occasional stray append or clear that can break the
    // length match for the rest of the phase.
    task automatic query_table(input int unsigned n);
        int unsigned sel;
        for (int unsigned i = 0; i < n; i++)
        begin
            sel = $urandom_range(99);
            if (sel < 4)
                send_item(rtra_pkg::FUNC_APPEND, pick_code(0), $urandom());
            else if (sel < 6)
                send_item(rtra_pkg::FUNC_CLEAR, 8'($urandom()), $urandom());
            else if (sel < 9)
                send_item(FUNC_UNUSED, 8'($urandom()), $urandom());
            else
                send_item(rtra_pkg::FUNC_QUERY, 8'($urandom()), pick_pos());
        end
    endtask

    // Receiver: checks each result transfer, idles at random, and holds off
    // once for a long stretch when the stimulus asks for it.
    initial
    begin
        bit hold_done;
        hold_done = 1'b0;
        m_axis_tready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
                board.check_result(m_axis_tdata);
            if (hold_request && !hold_done)
            begin
                hold_done = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
                m_axis_tready <= calm || ($urandom_range(99) >= 8);
        end
    end

    initial
    begin
        logic [7:0]  edge_codes [12];
        logic [31:0] len_v;
        int unsigned sel;
        board         = new();
        calm          = 1'b0;
        hold_request  = 1'b0;
        items_sent    = 0;
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tuser  <= rtra_pkg::FUNC_CLEAR;
        s_axis_tdata  <= '0;
        cfg_valid     <= 1'b0;
        cfg_data      <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty table, zero-length run, unused code
        send_item(rtra_pkg::FUNC_QUERY, 8'h00, 32'h0);
        send_item(FUNC_UNUSED, 8'hFF, 32'hFFFF_FFFF);
        send_item(rtra_pkg::FUNC_APPEND, 8'hFF, 32'h0);
        send_item(rtra_pkg::FUNC_QUERY, 8'hFF, 32'h0);
        // length register at its top: the running total cannot match
        write_table_len(32'hFFFF_FFFF);
        send_item(rtra_pkg::FUNC_QUERY, 8'h00, 32'h0);
        send_item(rtra_pkg::FUNC_CLEAR, 8'hFF, 32'hFFFF_FFFF);
        // shortest runs of every value, longest runs, zero run, mid bytes
        edge_codes = '{8'd0, 8'd1, 8'd2, 8'd3, 8'd4, 8'd5,
                       8'd252, 8'd253, 8'd254, 8'd255, 8'h7F, 8'h80};
        foreach (edge_codes[i])
            send_item(rtra_pkg::FUNC_APPEND, edge_codes[i], 32'h0);
        write_table_len(board.run_sum);
        send_item(rtra_pkg::FUNC_QUERY, 8'h00, 32'd0);
        send_item(rtra_pkg::FUNC_QUERY, 8'h00, 32'd1);
        send_item(rtra_pkg::FUNC_QUERY, 8'h00, 32'd2);
        send_item(rtra_pkg::FUNC_QUERY, 8'h00, 32'd3);
        send_item(rtra_pkg::FUNC_QUERY, 8'h00, board.table_len - 1);
        send_item(rtra_pkg::FUNC_QUERY, 8'h00, board.table_len);
        send_item(rtra_pkg::FUNC_QUERY, 8'h00, 32'hFFFF_FFFF);
        // an append after loading breaks the length match
        send_item(rtra_pkg::FUNC_APPEND, 8'h00, 32'h0);
        send_item(rtra_pkg::FUNC_QUERY, 8'h00, 32'd0);

        // Random phases: clear, load, set length, query. The first phase
        // loads a table spanning several blocks.
        items_sent = 0;
        while (items_sent < 1050)
        begin
            send_item(rtra_pkg::FUNC_CLEAR, 8'($urandom()), $urandom());
            if ((items_sent <= 1 || $urandom_range(9) == 0) && items_sent < 300)
                load_table($urandom_range(600, 300), $urandom_range(3));
            else
                load_table($urandom_range(40, 1), $urandom_range(3));
            sel = $urandom_range(99);
            if (sel < 80)
                len_v = board.run_sum;
            else if (sel < 88)
                len_v = board.run_sum + 1;
            else if (sel < 94)
                len_v = $urandom();
            else if (sel < 97)
                len_v = 32'h0;
            else
                len_v = 32'hFFFF_FFFF;
            write_table_len(len_v);
            query_table($urandom_range(16, 4));
        end

        // Long stretch with no idling; the receiver holds off meanwhile so
        // the block backs up into its input.
        send_item(rtra_pkg::FUNC_CLEAR, 8'h00, 32'h0);
        calm         = 1'b1;
        hold_request = 1'b1;
        for (int unsigned i = 0; i < 40; i++)
            send_item(rtra_pkg::FUNC_APPEND, 8'($urandom()), $urandom());
        write_table_len(board.run_sum);
        for (int unsigned i = 0; i < 12; i++)
            send_item(rtra_pkg::FUNC_QUERY, 8'($urandom()), pick_pos());
        send_item(rtra_pkg::FUNC_QUERY, 8'h00, board.table_len - 1);
        calm = 1'b0;

        s_axis_tvalid <= 1'b0;
        while (board.owed.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        if (board.errors == 0 && board.owed.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire
